[hw/rtl/ptc_pkg.sv]
// Package for the pressure/temperature compensation block.
// Holds the fixed-point offsets and reciprocal constants; no dependencies.
package ptc_pkg;

    localparam int     CAL_W        = 16;
    localparam int     RAW_W        = 16;
    localparam int     PRESS_W      = 16;
    localparam int     TEMP_W       = 11;
    localparam int     CFG_IDX_W    = 2;

    localparam int     UT1_OFS      = 20224;
    localparam int     C4_OFS       = 512;
    localparam int     SENS_OFS     = 24576 * 1024;
    localparam int     D1_OFS       = 7168;
    localparam int     C6_OFS       = 50;
    localparam int     T_OFS        = 204800;
    localparam longint P_BIAS       = 64'd250 << 29;
    localparam int     P_SHIFT      = 29;
    localparam int     OFF_SHIFT    = 14;
    localparam int     T_PRE_SHIFT  = 10;
    localparam int     RECIP10      = 52429;
    localparam int     RECIP10_SH   = 19;

    localparam int     PRESS_MAX    = 32767;
    localparam int     PRESS_MIN    = -32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_A = 2'd0,
        CFG_CAL_B = 2'd1,
        CFG_CAL_C = 2'd2,
        CFG_CAL_D = 2'd3
    } t_cfg_idx;

endpackage

[hw/rtl/pressure_temp_compensation.sv]
// Barometric sensor compensation: pressure in mbar and temperature in degC.
// Six-stage pipeline; depends on ptc_pkg.
//
// Usage:
//   Calibration words are written through i_cfg_we / i_cfg_idx / i_cfg_data,
//   index 0..3 for words a..d, one write per cycle, only while no sample is
//   in flight.
//   A sample (i_raw_pressure, i_raw_temperature) transfers at a rising edge
//   with start high and busy low. busy is always low: a new sample may be
//   given in every cycle.
//   Each result appears on o_pressure_mbar / o_temperature_c for one cycle
//   with o_done high. Throughput is one sample per cycle; the stage count
//   is set by the 29x17 pressure product and the divide-by-ten reciprocal
//   product, each in a stage of its own.
//   Reset (i_rst_n low, synchronous) clears the calibration words and drops
//   all samples in flight. The receiver cannot stall; results are shown once.
module pressure_temp_compensation (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ptc_pkg::CAL_W-1:0]             i_cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [ptc_pkg::RAW_W-1:0]             i_raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]             i_raw_temperature,
    output logic                                  o_done,
    output logic signed [ptc_pkg::PRESS_W-1:0]    o_pressure_mbar,
    output logic signed [ptc_pkg::TEMP_W-1:0]     o_temperature_c
);

    logic [15:0] r_cal_a, r_cal_b, r_cal_c, r_cal_d;

    logic [14:0] c1;
    logic [11:0] c2;
    logic [9:0]  c3;
    logic [9:0]  c4;
    logic [10:0] c5;
    logic [5:0]  c6;

    assign c1 = r_cal_a[15:1];
    assign c2 = {r_cal_c[5:0], r_cal_d[5:0]};
    assign c3 = r_cal_d[15:6];
    assign c4 = r_cal_c[15:6];
    assign c5 = {r_cal_a[0], r_cal_b[15:6]};
    assign c6 = r_cal_b[5:0];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_cal_d <= '0;
        end else if (i_cfg_we) begin
            case (ptc_pkg::t_cfg_idx'(i_cfg_idx))
                ptc_pkg::CFG_CAL_A: r_cal_a <= i_cfg_data;
                ptc_pkg::CFG_CAL_B: r_cal_b <= i_cfg_data;
                ptc_pkg::CFG_CAL_C: r_cal_c <= i_cfg_data;
                ptc_pkg::CFG_CAL_D: r_cal_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: dT and offset pressure
    logic               r_v1;
    logic signed [16:0] r_dt1, r_d1m1;
    logic signed [16:0] n_dt1, n_d1m1, ut1;

    assign ut1    = $signed({3'b000, c5, 3'b000}) + 17'(ptc_pkg::UT1_OFS);
    assign n_dt1  = $signed({1'b0, i_raw_temperature}) - ut1;
    assign n_d1m1 = $signed({1'b0, i_raw_pressure}) - 17'(ptc_pkg::D1_OFS);

    // stage 2: coefficient products
    logic               r_v2;
    logic signed [27:0] r_off_m2, r_sens_m2;
    logic signed [24:0] r_t_m2;
    logic signed [16:0] r_d1m2;
    logic signed [10:0] c4m;
    logic        [6:0]  c6p;

    assign c4m = $signed({1'b0, c4}) - 11'(ptc_pkg::C4_OFS);
    assign c6p = 7'(c6) + 7'(ptc_pkg::C6_OFS);

    // stage 3: OFF and SENS sums, scaled temperature
    logic               r_v3;
    logic signed [27:0] r_off3;
    logic signed [28:0] r_sens3;
    logic signed [24:0] r_t3;
    logic signed [16:0] r_d1m3;
    logic signed [28:0] sens_base;

    assign sens_base = $signed({4'b0000, c1, 10'b0}) + 29'(ptc_pkg::SENS_OFS);

    // stage 4: SENS x (D1 - offset), temperature magnitude
    logic               r_v4;
    logic signed [45:0] r_prod4;
    logic signed [27:0] r_off4;
    logic               r_tneg4;
    logic        [22:0] r_tabs4;

    // stage 5: pressure sum, divide-by-ten product
    logic               r_v5;
    logic signed [47:0] r_ps5;
    logic        [28:0] r_tq5;
    logic               r_tneg5;
    logic signed [47:0] n_ps5;

    assign n_ps5 = 48'(r_prod4) - (48'(r_off4) <<< ptc_pkg::OFF_SHIFT)
                 + 48'(ptc_pkg::P_BIAS);

    // stage 6: truncate toward zero, saturate
    logic signed [47:0] ps_b;
    logic signed [18:0] pq;
    logic signed [15:0] n_press;
    logic        [9:0]  tq;
    logic signed [10:0] n_temp;

    assign ps_b = r_ps5 + (r_ps5[47] ? 48'((64'd1 << ptc_pkg::P_SHIFT) - 64'd1) : 48'd0);
    assign pq   = ps_b[47:ptc_pkg::P_SHIFT];
    assign n_press = (pq > 19'(ptc_pkg::PRESS_MAX)) ? 16'(ptc_pkg::PRESS_MAX) :
                     (pq < 19'(ptc_pkg::PRESS_MIN)) ? 16'(ptc_pkg::PRESS_MIN) :
                     pq[15:0];
    assign tq     = r_tq5[ptc_pkg::RECIP10_SH +: 10];
    assign n_temp = r_tneg5 ? -$signed({1'b0, tq}) : $signed({1'b0, tq});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= start && !busy;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            o_done <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt1     <= n_dt1;
        r_d1m1    <= n_d1m1;

        r_off_m2  <= c4m * r_dt1;
        r_sens_m2 <= $signed({1'b0, c3}) * r_dt1;
        r_t_m2    <= $signed({1'b0, c6p}) * r_dt1;
        r_d1m2    <= r_d1m1;

        r_off3    <= $signed({4'b0000, c2, 12'b0}) + r_off_m2;
        r_sens3   <= sens_base + 29'(r_sens_m2);
        r_t3      <= r_t_m2 + 25'(ptc_pkg::T_OFS);
        r_d1m3    <= r_d1m2;

        r_prod4   <= r_sens3 * r_d1m3;
        r_off4    <= r_off3;
        r_tneg4   <= r_t3[24];
        r_tabs4   <= r_t3[24] ? 23'(-r_t3) : 23'(r_t3);

        r_ps5     <= n_ps5;
        r_tq5     <= r_tabs4[22:ptc_pkg::T_PRE_SHIFT] * 16'(ptc_pkg::RECIP10);
        r_tneg5   <= r_tneg4;

        o_pressure_mbar <= n_press;
        o_temperature_c <= n_temp;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_done)
        else $error("sample did not complete after six cycles");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_temperature_c >= -11'sd384 && o_temperature_c <= 11'sd520))
        else $error("temperature outside reachable range");

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_v4, 2))
        else $error("result strobe without a sample in flight");

endmodule

[tb/tb_pressure_temp_compensation.sv]
// Testbench for pressure_temp_compensation: a directed table, then random samples
// under three idle patterns; results are checked against the table where it gives
// them, else a fixed-point predictor. Depends on ptc_pkg and the block's RTL.
module tb_pressure_temp_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NUM_DIRECTED  = 20;
    localparam int     ITEMS_PER_CAL = 83;
    localparam int     SETTLE_CYCLES = 10;
    localparam int     DRAIN_LIMIT   = 1000;
    localparam longint P_SCALE       = longint'(1) << 29;

    typedef struct packed {
        logic signed [ptc_pkg::PRESS_W-1:0] pressure;
        logic signed [ptc_pkg::TEMP_W-1:0]  temperature;
    } t_reading;

    typedef struct packed {
        logic [ptc_pkg::CAL_W-1:0] cal_a;
        logic [ptc_pkg::CAL_W-1:0] cal_b;
        logic [ptc_pkg::CAL_W-1:0] cal_c;
        logic [ptc_pkg::CAL_W-1:0] cal_d;
        logic [ptc_pkg::RAW_W-1:0] raw_p;
        logic [ptc_pkg::RAW_W-1:0] raw_t;
        logic                      known;
        t_reading                  reading;
    } t_vector;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [ptc_pkg::CFG_IDX_W-1:0]      i_cfg_idx = ptc_pkg::CFG_CAL_A;
    logic [ptc_pkg::CAL_W-1:0]          i_cfg_data = '0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [ptc_pkg::RAW_W-1:0]          i_raw_pressure = '0;
    logic [ptc_pkg::RAW_W-1:0]          i_raw_temperature = '0;
    logic                               o_done;
    logic signed [ptc_pkg::PRESS_W-1:0] o_pressure_mbar;
    logic signed [ptc_pkg::TEMP_W-1:0]  o_temperature_c;

    logic [ptc_pkg::CAL_W-1:0] cal_a = '0;
    logic [ptc_pkg::CAL_W-1:0] cal_b = '0;
    logic [ptc_pkg::CAL_W-1:0] cal_c = '0;
    logic [ptc_pkg::CAL_W-1:0] cal_d = '0;
    t_reading                  expected_readings [$];
    int                        mismatch_count = 0;
    int                        idle_pct = 0;

    t_vector directed_vecs [NUM_DIRECTED] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd7168,  16'd20224, 1'b1,
          '{16'sd250, 11'sd20}},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0,     16'd20224, 1'b1,
          '{-16'sd86, 11'sd20}},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd65535, 16'd20224, 1'b1,
          '{16'sd2985, 11'sd20}},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd7168,  16'd0,     1'b1,
          '{-16'sd66, -11'sd78}},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd7168,  16'd65535, 1'b1,
          '{16'sd957, 11'sd241}},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA, 1'b0, '0},
        '{16'hFFFE, 16'h003F, 16'h0000, 16'hFFC0, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'hFFFE, 16'h003F, 16'h0000, 16'hFFC0, 16'h0000, 16'hFFFF, 1'b0, '0},
        '{16'h0001, 16'hFFC0, 16'h003F, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, '0},
        '{16'h0001, 16'hFFC0, 16'h003F, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h1234, 16'h8765, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 1'b0, '0}
    };

    pressure_temp_compensation DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .start             (start),
        .busy              (busy),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_done            (o_done),
        .o_pressure_mbar   (o_pressure_mbar),
        .o_temperature_c   (o_temperature_c)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_reading compensate(input logic [ptc_pkg::RAW_W-1:0] raw_p, raw_t);
        longint   c1, c2, c3, c4, c5, c6;
        longint   dt, off_s, sens_s, p_s, press, temp;
        t_reading r;
        c1 = longint'(cal_a[15:1]);
        c2 = longint'({cal_c[5:0], cal_d[5:0]});
        c3 = longint'(cal_d[15:6]);
        c4 = longint'(cal_c[15:6]);
        c5 = longint'({cal_a[0], cal_b[15:6]});
        c6 = longint'(cal_b[5:0]);
        dt = longint'(raw_t) - (8 * c5 + 20224);
        off_s  = 4096 * c2 + (c4 - 512) * dt;
        sens_s = 1024 * c1 + c3 * dt + 24576 * 1024;
        p_s    = sens_s * (longint'(raw_p) - 7168) - off_s * 16384 + 250 * P_SCALE;
        press  = p_s / P_SCALE;
        temp   = (204800 + dt * (c6 + 50)) / 10240;
        if (press > 32767) press = 32767;
        else if (press < -32768) press = -32768;
        if (temp > 1023) temp = 1023;
        else if (temp < -1024) temp = -1024;
        r.pressure    = press[ptc_pkg::PRESS_W-1:0];
        r.temperature = temp[ptc_pkg::TEMP_W-1:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report(input string what, input int want, input int got);
        mismatch_count++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic wait_idle();
        for (int n = 0; expected_readings.size() != 0 && n < DRAIN_LIMIT; n++)
            @(posedge i_clk);
    endtask

    task automatic write_word(input ptc_pkg::t_cfg_idx idx,
                              input logic [ptc_pkg::CAL_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [ptc_pkg::CAL_W-1:0] a, b, c, d);
        start <= 1'b0;
        wait_idle();
        write_word(ptc_pkg::CFG_CAL_A, a);
        write_word(ptc_pkg::CFG_CAL_B, b);
        write_word(ptc_pkg::CFG_CAL_C, c);
        write_word(ptc_pkg::CFG_CAL_D, d);
        i_cfg_we <= 1'b0;
        cal_a = a;
        cal_b = b;
        cal_c = c;
        cal_d = d;
    endtask

    task automatic send_sample(input logic [ptc_pkg::RAW_W-1:0] raw_p, raw_t,
                               input logic known, input t_reading given);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start             <= 1'b1;
        i_raw_pressure    <= raw_p;
        i_raw_temperature <= raw_t;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_readings.push_back(known ? given : compensate(raw_p, raw_t));
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_readings.size() == 0) begin
                report("unexpected transfer, pressure", 0, $signed(o_pressure_mbar));
            end else begin
                want = expected_readings.pop_front();
                if (o_pressure_mbar !== want.pressure)
                    report("pressure", $signed(want.pressure), $signed(o_pressure_mbar));
                if (o_temperature_c !== want.temperature)
                    report("temperature", $signed(want.temperature),
                           $signed(o_temperature_c));
            end
        end
    end

    initial begin
        t_vector                   v;
        t_reading                  none;
        logic [ptc_pkg::CAL_W-1:0] w;
        none = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            v = directed_vecs[i];
            if ({v.cal_a, v.cal_b, v.cal_c, v.cal_d} != {cal_a, cal_b, cal_c, cal_d})
                load_cal(v.cal_a, v.cal_b, v.cal_c, v.cal_d);
            send_sample(v.raw_p, v.raw_t, v.known, v.reading);
        end

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 36 : (phase == 1) ? 68 : 0;
            for (int s = 0; s < 4; s++) begin
                if (s == 0 && phase < 2) begin
                    w = (phase == 0) ? 16'hFFFF : 16'h0000;
                    load_cal(w, w, w, w);
                end else begin
                    load_cal(pick_value(), pick_value(), pick_value(), pick_value());
                end
                for (int k = 0; k < ITEMS_PER_CAL; k++)
                    send_sample(pick_value(), pick_value(), 1'b0, none);
            end
        end

        start <= 1'b0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (expected_readings.size() != 0)
                $display("%0t: %0d results never arrived", $time, expected_readings.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ptc_pkg.sv
hw/rtl/pressure_temp_compensation.sv
tb/tb_pressure_temp_compensation.sv
